>>> rtl/ggm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ggm_pkg;

  // Field element and stream widths.
  localparam int unsigned HalfW     = 64;
  localparam int unsigned BlockW    = 2 * HalfW;
  localparam int unsigned ChunkW    = 16;
  localparam int unsigned NumChunks = BlockW / ChunkW;
  localparam int unsigned PartW     = BlockW + ChunkW - 1;
  localparam int unsigned ProdW     = 2 * BlockW - 1;
  localparam int unsigned HiW       = ProdW - BlockW;
  localparam int unsigned TapW      = 8;
  localparam int unsigned FoldW     = HiW + TapW - 1;
  localparam int unsigned OverW     = FoldW - BlockW;
  localparam int unsigned LastW     = OverW + TapW;
  localparam int unsigned CfgIdxW   = 2;

  // Low terms of x^128 + x^7 + x^2 + x + 1 in plain bit order.
  localparam logic [TapW-1:0] ReduceTaps = 8'h87;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegKeyHigh = 2'd0,
    RegKeyLow  = 2'd1
  } cfg_reg_e;

  typedef logic [BlockW-1:0]                elem_t;
  typedef logic [ProdW-1:0]                 prod_t;
  typedef logic [NumChunks-1:0][PartW-1:0]  part_arr_t;

  // Swap between the GCM reflected order and plain polynomial order.
  function automatic elem_t bit_rev(input elem_t v);
    elem_t r;
    for (int i = 0; i < BlockW; i++) begin
      r[i] = v[BlockW-1-i];
    end
    return r;
  endfunction

  // Carry-less product of the key with one chunk of the block.
  function automatic logic [PartW-1:0] clmul_part(input elem_t h,
                                                  input logic [ChunkW-1:0] x);
    logic [PartW-1:0] r;
    r = '0;
    for (int i = 0; i < ChunkW; i++) begin
      if (x[i]) begin
        r = r ^ (PartW'(h) << i);
      end
    end
    return r;
  endfunction

  // Reduce a full carry-less product modulo the field polynomial.
  function automatic elem_t gf_reduce(input prod_t p);
    logic [HiW-1:0]   hi;
    logic [FoldW-1:0] t;
    logic [OverW-1:0] th;
    logic [LastW-1:0] u;
    hi = p[ProdW-1:BlockW];
    t  = '0;
    for (int k = 0; k < TapW; k++) begin
      if (ReduceTaps[k]) begin
        t = t ^ (FoldW'(hi) << k);
      end
    end
    th = t[FoldW-1:BlockW];
    u  = '0;
    for (int k = 0; k < TapW; k++) begin
      if (ReduceTaps[k]) begin
        u = u ^ (LastW'(th) << k);
      end
    end
    return p[BlockW-1:0] ^ t[BlockW-1:0] ^ BlockW'(u);
  endfunction

endpackage

`default_nettype wire

>>> rtl/gcm_gf128_multiply.sv
// Throughput: one word per cycle while the output is not stalled; three register
// stages (partial products, combine, reduction) each hold a word in that order,
// and a stall holds them in place.
// Reset clears the stage valid bits and both key registers; a zero key gives
// a zero product.
`timescale 1ns / 1ps
`default_nettype none

module gcm_gf128_multiply (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [ggm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [ggm_pkg::HalfW-1:0]    cfg_data_i,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [63:0] block_high, [127:64] block_low
  input  wire  [ggm_pkg::BlockW-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [63:0] product_high, [127:64] product_low
  output logic [ggm_pkg::BlockW-1:0]   m_axis_tdata
);
  import ggm_pkg::*;

  logic [HalfW-1:0] key_high_q, key_low_q;
  elem_t            a_poly, h_poly, res;
  part_arr_t        pp;
  prod_t            prod;
  logic             v1, v2, r2, r3;

  // Key registers; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegKeyHigh: key_high_q <= cfg_data_i;
        RegKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Convert block and key from the reflected order to plain polynomials.
  assign a_poly = bit_rev({s_axis_tdata[HalfW-1:0], s_axis_tdata[BlockW-1:HalfW]});
  assign h_poly = bit_rev({key_high_q, key_low_q});

  ggm_partial u_partial (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .a_i     (a_poly),
    .h_i     (h_poly),
    .valid_o (v1),
    .ready_i (r2),
    .pp_o    (pp)
  );

  ggm_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (r2),
    .pp_i    (pp),
    .valid_o (v2),
    .ready_i (r3),
    .prod_o  (prod)
  );

  ggm_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (r3),
    .prod_i  (prod),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // Result back to two big-endian halves.
  assign m_axis_tdata = {res[HalfW-1:0], res[BlockW-1:HalfW]};

  // Input back-pressure only when every stage holds a word.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1 && v2 && m_axis_tvalid))
    else $error("input stalled with a free stage");

  // An accepted word lands in the first stage.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1)
    else $error("accepted word lost at first stage");

  // A word held in the combine stage is not dropped while the next stage stalls.
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2 && !r3) |=> (v2 && $stable(prod)))
    else $error("combine stage word lost during stall");

endmodule

`default_nettype wire

>>> rtl/ggm_partial.sv
`timescale 1ns / 1ps
`default_nettype none

module ggm_partial (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  wire ggm_pkg::elem_t   a_i,
  input  wire ggm_pkg::elem_t   h_i,
  output logic                  valid_o,
  input  wire                   ready_i,
  output ggm_pkg::part_arr_t    pp_o
);
  import ggm_pkg::*;

  logic      valid_q;
  part_arr_t pp_d, pp_q;

  // The stage takes a word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  // One partial product per chunk of the block.
  always_comb begin
    for (int j = 0; j < NumChunks; j++) begin
      pp_d[j] = clmul_part(h_i, a_i[j*ChunkW +: ChunkW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pp_q <= pp_d;
    end
  end

  assign valid_o = valid_q;
  assign pp_o    = pp_q;

endmodule

`default_nettype wire

>>> rtl/ggm_combine.sv
`timescale 1ns / 1ps
`default_nettype none

module ggm_combine (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     valid_i,
  output logic                    ready_o,
  input  wire ggm_pkg::part_arr_t pp_i,
  output logic                    valid_o,
  input  wire                     ready_i,
  output ggm_pkg::prod_t          prod_o
);
  import ggm_pkg::*;

  logic  valid_q;
  prod_t prod_d, prod_q;

  assign ready_o = !valid_q || ready_i;

  // Align each partial product to its chunk and sum them over GF(2).
  always_comb begin
    prod_d = '0;
    for (int j = 0; j < NumChunks; j++) begin
      prod_d = prod_d ^ (ProdW'(pp_i[j]) << (j * ChunkW));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

>>> rtl/ggm_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module ggm_reduce (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   valid_i,
  output logic                  ready_o,
  input  wire ggm_pkg::prod_t   prod_i,
  output logic                  valid_o,
  input  wire                   ready_i,
  output ggm_pkg::elem_t        res_o
);
  import ggm_pkg::*;

  logic  valid_q;
  elem_t res_d, res_q;

  assign ready_o = !valid_q || ready_i;

  // Fold the high half back and return to the reflected order.
  assign res_d = bit_rev(gf_reduce(prod_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire
